// ===== hw/rtl/euler_rotate_translate_point_top_macros.svh =====
// assertion macros used by the checker file
`ifndef EULER_ROTATE_TRANSLATE_POINT_TOP_MACROS_SVH
`define EULER_ROTATE_TRANSLATE_POINT_TOP_MACROS_SVH

// same-cycle implication
`define ERP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/erp_pkg.sv =====
// shared types, constants and functions of the point transform block
package erp_pkg;

  localparam int COORD_BITS     = 32;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = COORD_BITS + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int WIDE_W = SUM_W - TRIG_FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;
  localparam int TURN_BITS    = 32;
  localparam int QUARTER_BITS = TURN_BITS - 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]     trig_t;

  localparam trig_t TRIG_ONE = trig_t'(1) << TRIG_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH   = 3'd0,
    REG_YAW     = 3'd1,
    REG_ROLL    = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_PITCH = 2'd0,
    AXIS_YAW   = 2'd1,
    AXIS_ROLL  = 2'd2
  } axis_e;

  typedef struct packed {
    logic  valid;
    axis_e axis;
    trig_t cos_v;
    trig_t sin_v;
  } trig_res_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_BITS:0] top;
    top = v[WIDE_W-1:COORD_BITS-1];
    if ((&top) || (~|top)) begin
      return v[COORD_BITS-1:0];
    end
    return v[WIDE_W-1] ? coord_t'({1'b1, {(COORD_BITS-1){1'b0}}})
                       : coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  endfunction

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [QUARTER_BITS-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [QUARTER_BITS-1:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10680862;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      5'd24:   r = 30'd41;
      5'd25:   r = 30'd20;
      5'd26:   r = 30'd10;
      5'd27:   r = 30'd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/erp_if.sv =====
// handshake channel interfaces: model point in, world point out, register writes
interface erp_model_if;
  import erp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t model_x;
  coord_t model_y;
  coord_t model_z;
  modport source (output valid, output model_x, output model_y, output model_z, input ready);
  modport sink   (input valid, input model_x, input model_y, input model_z, output ready);
endinterface

interface erp_world_if;
  import erp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;
  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface erp_cfg_if;
  import erp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/euler_rotate_translate_point_top.sv =====
// top level: pitch, yaw, roll rotation and translation of a model point
//
// in_i carries one model point (x, y, z, signed Q16.16) per item; out_o returns
// the world point, each coordinate saturated to 32 bits. cfg_i writes registers:
// index 0..2 set pitch, yaw and roll as binary angles (65536 per turn), index
// 3..5 set the x, y, z offset; other indexes are ignored.
// An accepted item reaches out_o through two stages per rotation (products, then
// sum, round and clamp) and one offset stage.
// Throughput is one item per cycle while no angle update runs; every stage has
// its own valid bit and takes a new item whenever it is empty or its successor
// moves, so a stalled receiver only halts the stages that are full and bubbles
// close up behind it. An angle write starts the cordic unit, which runs 28
// iterations, a rounding step and the register update (a zero remainder skips
// the iterations); cfg_i.ready and in_i.ready stay low meanwhile.
// Reset sets all angles and offsets to zero (cosine one, sine zero) and empties
// the pipeline.
module euler_rotate_translate_point_top (
  input logic        clk_i,
  input logic        rst_ni,
  erp_model_if.sink  in_i,
  erp_world_if.source out_o,
  erp_cfg_if.sink    cfg_i
);
  import erp_pkg::*;

  trig_t cos_pitch_q, sin_pitch_q, cos_yaw_q, sin_yaw_q, cos_roll_q, sin_roll_q;
  coord_t shift_x_q, shift_y_q, shift_z_q;

  logic      busy, cfg_acc, trig_start;
  axis_e     trig_axis;
  trig_res_t trig_res;

  logic   r1_in_rdy, r1_vld, r2_rdy, r2_vld, r3_rdy, r3_vld, out_rdy, out_vld_q;
  coord_t r1_y, r1_z, r1_x, r2_z, r2_x, r2_y, r3_x, r3_y, r3_z;
  coord_t wx_q, wy_q, wz_q;
  logic signed [COORD_BITS:0] sum_x, sum_y, sum_z;

  assign cfg_i.ready = !busy;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_comb begin
    trig_start = 1'b0;
    trig_axis  = AXIS_PITCH;
    case (cfg_reg_e'(cfg_i.index))
      REG_PITCH: begin
        trig_start = cfg_acc;
        trig_axis  = AXIS_PITCH;
      end
      REG_YAW: begin
        trig_start = cfg_acc;
        trig_axis  = AXIS_YAW;
      end
      REG_ROLL: begin
        trig_start = cfg_acc;
        trig_axis  = AXIS_ROLL;
      end
      default: begin
        trig_start = 1'b0;
      end
    endcase
  end

  erp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .axis_i  (trig_axis),
    .angle_i (cfg_i.data[ANGLE_BITS-1:0]),
    .busy_o  (busy),
    .res_o   (trig_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_pitch_q <= TRIG_ONE;
      sin_pitch_q <= '0;
      cos_yaw_q   <= TRIG_ONE;
      sin_yaw_q   <= '0;
      cos_roll_q  <= TRIG_ONE;
      sin_roll_q  <= '0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      shift_z_q   <= '0;
    end else begin
      if (trig_res.valid) begin
        case (trig_res.axis)
          AXIS_PITCH: begin
            cos_pitch_q <= trig_res.cos_v;
            sin_pitch_q <= trig_res.sin_v;
          end
          AXIS_YAW: begin
            cos_yaw_q <= trig_res.cos_v;
            sin_yaw_q <= trig_res.sin_v;
          end
          AXIS_ROLL: begin
            cos_roll_q <= trig_res.cos_v;
            sin_roll_q <= trig_res.sin_v;
          end
          default: begin
          end
        endcase
      end
      if (cfg_acc) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_SHIFT_X: shift_x_q <= cfg_i.data[COORD_BITS-1:0];
          REG_SHIFT_Y: shift_y_q <= cfg_i.data[COORD_BITS-1:0];
          REG_SHIFT_Z: shift_z_q <= cfg_i.data[COORD_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_i.ready = r1_in_rdy && !busy;

  // about x: y' = y*c - z*s, z' = y*s + z*c
  erp_rot u_rot_pitch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid && !busy),
    .in_ready_o  (r1_in_rdy),
    .a_i         (in_i.model_y),
    .b_i         (in_i.model_z),
    .pass_i      (in_i.model_x),
    .cos_i       (cos_pitch_q),
    .sin_i       (sin_pitch_q),
    .out_valid_o (r1_vld),
    .out_ready_i (r2_rdy),
    .u_o         (r1_y),
    .v_o         (r1_z),
    .pass_o      (r1_x)
  );

  // about y: z' = z*c - x*s, x' = z*s + x*c
  erp_rot u_rot_yaw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r1_vld),
    .in_ready_o  (r2_rdy),
    .a_i         (r1_z),
    .b_i         (r1_x),
    .pass_i      (r1_y),
    .cos_i       (cos_yaw_q),
    .sin_i       (sin_yaw_q),
    .out_valid_o (r2_vld),
    .out_ready_i (r3_rdy),
    .u_o         (r2_z),
    .v_o         (r2_x),
    .pass_o      (r2_y)
  );

  // about z: x' = x*c - y*s, y' = x*s + y*c
  erp_rot u_rot_roll (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r2_vld),
    .in_ready_o  (r3_rdy),
    .a_i         (r2_x),
    .b_i         (r2_y),
    .pass_i      (r2_z),
    .cos_i       (cos_roll_q),
    .sin_i       (sin_roll_q),
    .out_valid_o (r3_vld),
    .out_ready_i (out_rdy),
    .u_o         (r3_x),
    .v_o         (r3_y),
    .pass_o      (r3_z)
  );

  // offset stage
  assign out_rdy = !out_vld_q || out_o.ready;
  assign sum_x   = (COORD_BITS+1)'(r3_x) + (COORD_BITS+1)'(shift_x_q);
  assign sum_y   = (COORD_BITS+1)'(r3_y) + (COORD_BITS+1)'(shift_y_q);
  assign sum_z   = (COORD_BITS+1)'(r3_z) + (COORD_BITS+1)'(shift_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= r3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && r3_vld) begin
      wx_q <= sat_coord(WIDE_W'(sum_x));
      wy_q <= sat_coord(WIDE_W'(sum_y));
      wz_q <= sat_coord(WIDE_W'(sum_z));
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.world_x = wx_q;
  assign out_o.world_y = wy_q;
  assign out_o.world_z = wz_q;

endmodule

// ===== hw/rtl/erp_cordic.sv =====
// iterative cordic unit deriving cosine and sine of a binary angle
module erp_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  erp_pkg::axis_e              axis_i,
  input  logic [erp_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                        busy_o,
  output erp_pkg::trig_res_t          res_o
);
  import erp_pkg::*;

  localparam int RND_SH = QUARTER_BITS - TRIG_FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032874);
  localparam logic signed [CORDIC_W-1:0] ONE_Q30  = CORDIC_W'(1) << QUARTER_BITS;
  localparam logic signed [CORDIC_W-1:0] RND_TRIG = CORDIC_W'(1) << (RND_SH - 1);
  localparam logic signed [CORDIC_W-1:0] ONE_F    = CORDIC_W'(1) << TRIG_FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  function automatic trig_t round_trig(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + RND_TRIG) >>> RND_SH;
    if (r > ONE_F) begin
      r = ONE_F;
    end else if (r < -ONE_F) begin
      r = -ONE_F;
    end
    return r[TRIG_W-1:0];
  endfunction

  state_e state_q, state_d;
  quad_e  quad_q, quad_d;
  axis_e  axis_q, axis_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [CORDIC_W-1:0] dx, dy, at, c_sel, s_sel;
  logic [TURN_BITS-1:0] turn;
  trig_res_t res_q, res_d;

  assign turn   = {angle_i, {(TURN_BITS-ANGLE_BITS){1'b0}}};
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign at     = signed'({{(CORDIC_W-QUARTER_BITS){1'b0}}, atan_turn(step_q)});
  assign busy_o = (state_q != ST_IDLE) || res_q.valid;
  assign res_o  = res_q;

  always_comb begin
    case (quad_q)
      QUAD_0: begin
        c_sel = x_q;
        s_sel = y_q;
      end
      QUAD_1: begin
        c_sel = -y_q;
        s_sel = x_q;
      end
      QUAD_2: begin
        c_sel = -x_q;
        s_sel = -y_q;
      end
      default: begin
        c_sel = y_q;
        s_sel = -x_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    quad_d  = quad_q;
    axis_d  = axis_q;
    step_d  = step_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    res_d   = res_q;
    res_d.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          quad_d = quad_e'(turn[TURN_BITS-1:QUARTER_BITS]);
          axis_d = axis_i;
          step_d = '0;
          y_d    = '0;
          z_d    = signed'({{(CORDIC_W-QUARTER_BITS){1'b0}}, turn[QUARTER_BITS-1:0]});
          if (turn[QUARTER_BITS-1:0] == '0) begin
            x_d     = ONE_Q30;
            state_d = ST_FIN;
          end else begin
            x_d     = GAIN_Q30;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!z_q[CORDIC_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d.valid = 1'b1;
        res_d.axis  = axis_q;
        res_d.cos_v = round_trig(c_sel);
        res_d.sin_v = round_trig(s_sel);
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    axis_q <= axis_d;
    step_q <= step_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

endmodule

// ===== hw/rtl/erp_rot.sv =====
// two-stage plane rotation: u = a*c - b*s, v = a*s + b*c, with rounding and clamp
module erp_rot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  erp_pkg::coord_t a_i,
  input  erp_pkg::coord_t b_i,
  input  erp_pkg::coord_t pass_i,
  input  erp_pkg::trig_t  cos_i,
  input  erp_pkg::trig_t  sin_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output erp_pkg::coord_t u_o,
  output erp_pkg::coord_t v_o,
  output erp_pkg::coord_t pass_o
);
  import erp_pkg::*;

  logic signed [PROD_W-1:0] ac_q, bs_q, as_q, bc_q;
  logic signed [SUM_W-1:0]  u_sum, v_sum;
  coord_t pass1_q, u_q, v_q, pass2_q;
  logic   mul_vld_q, sum_vld_q, mul_rdy, sum_rdy;

  assign sum_rdy = !sum_vld_q || out_ready_i;
  assign mul_rdy = !mul_vld_q || sum_rdy;

  assign u_sum = SUM_W'(ac_q) - SUM_W'(bs_q) + RND_HALF;
  assign v_sum = SUM_W'(as_q) + SUM_W'(bc_q) + RND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_vld_q <= in_valid_i;
      end
      if (sum_rdy) begin
        sum_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && in_valid_i) begin
      ac_q    <= PROD_W'(a_i) * PROD_W'(cos_i);
      bs_q    <= PROD_W'(b_i) * PROD_W'(sin_i);
      as_q    <= PROD_W'(a_i) * PROD_W'(sin_i);
      bc_q    <= PROD_W'(b_i) * PROD_W'(cos_i);
      pass1_q <= pass_i;
    end
    if (sum_rdy && mul_vld_q) begin
      u_q     <= sat_coord(u_sum[SUM_W-1:TRIG_FRAC_BITS]);
      v_q     <= sat_coord(v_sum[SUM_W-1:TRIG_FRAC_BITS]);
      pass2_q <= pass1_q;
    end
  end

  assign in_ready_o  = mul_rdy;
  assign out_valid_o = sum_vld_q;
  assign u_o         = u_q;
  assign v_o         = v_q;
  assign pass_o      = pass2_q;

endmodule

// ===== hw/rtl/erp_checker.sv =====
// port-level checks of the point transform block, bound to the top level
`include "euler_rotate_translate_point_top_macros.svh"

module erp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input erp_pkg::coord_t                world_x_i,
  input erp_pkg::coord_t                world_y_i,
  input erp_pkg::coord_t                world_z_i,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_i,
  input logic [erp_pkg::CFG_IDX_W-1:0]  cfg_index_i
);
  import erp_pkg::*;

  logic angle_wr;

  assign angle_wr = cfg_valid_i && cfg_ready_i &&
                    (cfg_index_i == REG_PITCH || cfg_index_i == REG_YAW ||
                     cfg_index_i == REG_ROLL);

  `ERP_ASSERT_NEXT(a_angle_blocks_in, clk_i, rst_ni, angle_wr, !in_ready_i, "item taken during angle update")
  `ERP_ASSERT_NEXT(a_angle_blocks_cfg, clk_i, rst_ni, angle_wr, !cfg_ready_i, "write taken during angle update")
  `ERP_ASSERT_NOW(a_in_implies_cfg, clk_i, rst_ni, in_ready_i, cfg_ready_i, "input open while busy")
  `ERP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `ERP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(world_x_i) && $stable(world_y_i) && $stable(world_z_i), "stalled result changed")

endmodule

bind euler_rotate_translate_point_top erp_checker u_erp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .world_x_i   (out_o.world_x),
  .world_y_i   (out_o.world_y),
  .world_z_i   (out_o.world_z),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_index_i (cfg_i.index)
);
